// ===== rtl/siiee_pkg.sv =====
// ============================================================================
// siiee_pkg: shared codes for the SII EEPROM emulator
// Command codes, result kinds and fixed widths used by the emulator logic.
// ============================================================================
package siiee_pkg;

    localparam int CMD_W  = 4;
    localparam int WORD_W = 16;
    localparam int KIND_W = 3;
    localparam int DATA_W = 64;

    // Command codes carried on the cmd field.
    localparam logic [CMD_W-1:0] CMD_NOP    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RELOAD = 4'd4;
    localparam logic [CMD_W-1:0] CMD_TICK   = 4'd8;

    // Result kinds carried on the kind field.
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WACK     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELOAD   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ADDR_ERR = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FLUSH    = 3'd5;

    // Erased EEPROM word, also the saturation value of the delay count.
    localparam logic [WORD_W-1:0] WORD_ERASED = 16'hFFFF;

    // Delay after reset before a flush request, in ticks.
    localparam logic [WORD_W-1:0] FLUSH_DELAY_RESET = 16'd1000;

    // Offset of the second half of the info header.
    localparam int HEADER_HALF = 4;

endpackage

// ===== rtl/sii_eeprom_emulator_top.sv =====
// ============================================================================
// sii_eeprom_emulator_top: SII EEPROM emulation store
// Word store with read, write, header reload and a delayed flush request.
// ============================================================================
// Usage:
// Requests enter on the in_valid/in_ready channel with cmd, address and
// write_data. Results leave on the out_valid/out_ready channel as kind, data
// and last; a reload gives two results, every other request at most one.
// The flush delay is written through cfg_valid/cfg_ready/cfg_data; the user
// must write it while the block is idle, which the block does not enforce.
// cfg_ready is always high. After reset the block runs a clearing pass that
// sets every word to 0xFFFF; in_ready stays low during it.
// Requests are handled one at a time. A nop, a tick or a request with a
// single immediate result is done in decode; a read runs decode, four word
// reads through the single read port of the store and result load; a reload
// runs two bursts of four, eight word reads in all.
// Results go to an output register, so a new request is accepted while a
// result still waits. If the receiver stalls and a new result is ready, the
// sequencer holds in place until the output register frees up.
// ============================================================================
module sii_eeprom_emulator_top #(
    parameter int STORE_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  cmd,
    input  logic [15:0] address,
    input  logic [15:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [63:0] data,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(STORE_WORDS - 1);
    localparam logic [16:0]   STORE_LIMIT = 17'(STORE_WORDS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [3:0]    cmd_reg, cmd_next;
    logic [15:0]   addr_reg, addr_next;
    logic [15:0]   wdata_reg, wdata_next;
    logic [AW-1:0] base_reg, base_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          second_reg, second_next;
    logic [63:0]   gather_reg, gather_next;
    logic          dirty_reg, dirty_next;
    logic [15:0]   since_write_reg, since_write_next;
    logic [15:0]   flush_delay_reg, flush_delay_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    kind_reg, kind_next;
    logic [63:0]   data_reg, data_next;
    logic          last_reg, last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    logic          out_free;
    logic          rd_oob;
    logic          wr_oob;
    logic [15:0]   tick_inc;
    logic          single_need;
    logic [2:0]    single_kind;
    logic          is_reload;

    siiee_ram #(
        .WIDTH (siiee_pkg::WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A read needs all four words inside the store; a write needs its one word.
    assign rd_oob    = ({1'b0, addr_reg} + 17'd3) >= STORE_LIMIT;
    assign wr_oob    = {1'b0, addr_reg} >= STORE_LIMIT;
    assign tick_inc  = (since_write_reg == siiee_pkg::WORD_ERASED) ? since_write_reg
                                                                   : since_write_reg + 16'd1;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_reload = (cmd_reg == siiee_pkg::CMD_RELOAD);

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        wdata_next       = wdata_reg;
        base_next        = base_reg;
        cnt_next         = cnt_reg;
        second_next      = second_reg;
        gather_next      = gather_reg;
        dirty_next       = dirty_reg;
        since_write_next = since_write_reg;
        flush_delay_next = flush_delay_reg;
        out_valid_next   = out_valid_reg;
        kind_next        = kind_reg;
        data_next        = data_reg;
        last_next        = last_reg;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg[AW-1:0];
        ram_wdata        = wdata_reg;
        ram_re           = 1'b0;
        ram_raddr        = base_reg + AW'(cnt_reg);
        single_need      = 1'b0;
        single_kind      = siiee_pkg::KIND_INVALID;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            flush_delay_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = siiee_pkg::WORD_ERASED;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    addr_next  = address;
                    wdata_next = write_data;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                case (cmd_reg)
                    siiee_pkg::CMD_NOP:
                    begin
                        state_next = ST_IDLE;
                    end
                    siiee_pkg::CMD_READ:
                    begin
                        if (rd_oob)
                        begin
                            single_need = 1'b1;
                            single_kind = siiee_pkg::KIND_ADDR_ERR;
                        end
                        else
                        begin
                            base_next   = addr_reg[AW-1:0];
                            cnt_next    = 2'd0;
                            second_next = 1'b0;
                            state_next  = ST_RD;
                        end
                    end
                    siiee_pkg::CMD_WRITE:
                    begin
                        single_need = 1'b1;
                        if (wr_oob)
                        begin
                            single_kind = siiee_pkg::KIND_ADDR_ERR;
                        end
                        else
                        begin
                            single_kind = siiee_pkg::KIND_WACK;
                            if (out_free)
                            begin
                                ram_we           = 1'b1;
                                dirty_next       = 1'b1;
                                since_write_next = '0;
                            end
                        end
                    end
                    siiee_pkg::CMD_RELOAD:
                    begin
                        base_next   = '0;
                        cnt_next    = 2'd0;
                        second_next = 1'b0;
                        state_next  = ST_RD;
                    end
                    siiee_pkg::CMD_TICK:
                    begin
                        if (!dirty_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (tick_inc >= flush_delay_reg)
                        begin
                            single_need = 1'b1;
                            single_kind = siiee_pkg::KIND_FLUSH;
                            if (out_free)
                            begin
                                dirty_next       = 1'b0;
                                since_write_next = '0;
                            end
                        end
                        else
                        begin
                            since_write_next = tick_inc;
                            state_next       = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        single_need = 1'b1;
                        single_kind = siiee_pkg::KIND_INVALID;
                    end
                endcase

                if (single_need && out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = single_kind;
                    data_next      = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_RD:
            begin
                // One word read per cycle; the word asked for last cycle
                // shifts in from the top so the first word ends lowest.
                ram_re = 1'b1;
                if (cnt_reg != 2'd0)
                begin
                    gather_next = {ram_rdata, gather_reg[63:16]};
                end
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end

            ST_EMIT:
            begin
                // The fourth word sits in the read register until the next read.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = is_reload ? siiee_pkg::KIND_RELOAD : siiee_pkg::KIND_READ;
                    data_next      = {ram_rdata, gather_reg[63:16]};
                    last_next      = !(is_reload && !second_reg);
                    if (is_reload && !second_reg)
                    begin
                        second_next = 1'b1;
                        base_next   = AW'(siiee_pkg::HEADER_HALF);
                        cnt_next    = 2'd0;
                        state_next  = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            dirty_reg       <= 1'b0;
            since_write_reg <= '0;
            flush_delay_reg <= siiee_pkg::FLUSH_DELAY_RESET;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= 2'd0;
            second_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            dirty_reg       <= dirty_next;
            since_write_reg <= since_write_next;
            flush_delay_reg <= flush_delay_next;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
            second_reg      <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        wdata_reg  <= wdata_next;
        base_reg   <= base_next;
        gather_reg <= gather_next;
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    // The dirty mark only clears together with a flush request being loaded.
    a_flush_on_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(dirty_reg) |-> (out_valid_reg && kind_reg == siiee_pkg::KIND_FLUSH))
        else $error("dirty mark cleared without a flush request");

    // A running delay count implies a pending dirty store.
    a_count_needs_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (since_write_reg != 16'd0) |-> dirty_reg)
        else $error("delay count running while store is clean");

    // The store port never reads and writes in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("store read and write in the same cycle");

    // The emit state is entered only after a full four-word read burst.
    a_emit_after_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && $past(state_reg) != ST_EMIT) |->
            ($past(state_reg) == ST_RD && $past(cnt_reg) == 2'd3))
        else $error("emit entered without a complete read burst");

endmodule

// ===== rtl/siiee_ram.sv =====
// ============================================================================
// siiee_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ============================================================================
module siiee_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
